/* hdl/u2u8_pkg.sv */
// Package for the UTF-16BE / UTF-32BE / Latin-1 to UTF-8 transcoder.
// Holds the command type between front and back, format codes and UTF-8 helpers.
// No dependencies.
`timescale 1ns / 1ps
package u2u8_pkg;

	localparam logic [1:0] FMT_LATIN1 = 2'd0;
	localparam logic [1:0] FMT_UTF16  = 2'd1;
	localparam logic [1:0] FMT_UTF32  = 2'd2;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
	localparam logic [31:0]     CP_MAX    = 32'h0010FFFF;
	localparam logic [15:0]     HIGH_LO   = 16'hD800;
	localparam logic [15:0]     HIGH_HI   = 16'hDBFF;
	localparam logic [15:0]     LOW_LO    = 16'hDC00;
	localparam logic [15:0]     LOW_HI    = 16'hDFFF;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	// One queue entry: up to one decoded code point, then an optional
	// replacement for a dangling high surrogate, and the end-of-string mark.
	typedef struct packed {
		logic            has_cp;
		logic [CP_W-1:0] cp;
		logic            has_repl;
		logic            last;
	} cmd_t;

	// Number of UTF-8 bytes minus one.
	function automatic logic [1:0] utf8_len_m1(input logic [CP_W-1:0] cp);
		logic [1:0] r;
		if (cp <= 21'h00007F)      r = 2'd0;
		else if (cp <= 21'h0007FF) r = 2'd1;
		else if (cp <= 21'h00FFFF) r = 2'd2;
		else                       r = 2'd3;
		return r;
	endfunction

	// Byte number idx of the UTF-8 form of cp.
	function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
			input logic [1:0] len_m1, input logic [1:0] idx);
		logic [1:0] trail;
		logic [5:0] cont_bits;
		logic [7:0] r;
		trail = len_m1 - idx;
		unique case (trail)
			2'd0: cont_bits = cp[5:0];
			2'd1: cont_bits = cp[11:6];
			2'd2: cont_bits = cp[17:12];
			default: cont_bits = {3'b000, cp[20:18]};
		endcase
		if (idx != 2'd0) begin
			r = CONT | {2'b00, cont_bits};
		end else begin
			unique case (len_m1)
				2'd0: r = cp[7:0];
				2'd1: r = LEAD2 | {3'b000, cp[10:6]};
				2'd2: r = LEAD3 | {4'b0000, cp[15:12]};
				default: r = LEAD4 | {5'b00000, cp[20:18]};
			endcase
		end
		return r;
	endfunction

endpackage

/* hdl/u2u8_front.sv */
// Front end: holds the format register, assembles source units and classifies
// them into code-point commands. Depends on u2u8_pkg.
`timescale 1ns / 1ps
module u2u8_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 source_format_we,
	input  logic [1:0]           source_format,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic                 q_full,
	output logic                 q_push,
	output u2u8_pkg::cmd_t       q_data
);
	import u2u8_pkg::*;

	logic [1:0]  fmt_q;
	logic [1:0]  byte_position_q;
	logic [23:0] unit_bytes_q;
	logic        high_pending_q;
	logic [9:0]  high_bits_q;

	logic [1:0]  pos_n;
	logic [23:0] unit_n;
	logic        hp_n;
	logic [9:0]  hb_n;
	logic        has_cp;
	logic [CP_W-1:0] cp;
	logic [15:0] u16;
	logic [31:0] u32;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign u16      = {unit_bytes_q[7:0], in_byte};
	assign u32      = {unit_bytes_q, in_byte};

	always_comb begin
		pos_n  = byte_position_q;
		unit_n = unit_bytes_q;
		hp_n   = high_pending_q;
		hb_n   = high_bits_q;
		has_cp = 1'b0;
		cp     = '0;
		if (fmt_q == FMT_UTF16) begin
			if (byte_position_q == 2'd0) begin
				unit_n = {unit_bytes_q[15:0], in_byte};
				pos_n  = 2'd1;
			end else begin
				pos_n = 2'd0;
				if (high_pending_q) begin
					hp_n   = 1'b0;
					hb_n   = '0;
					has_cp = 1'b1;
					if (u16 >= LOW_LO && u16 <= LOW_HI)
						cp = SUPP_BASE + {1'b0, high_bits_q, u16[9:0]};
					else
						cp = REPL_CP;
				end else if (u16 >= HIGH_LO && u16 <= HIGH_HI) begin
					hp_n = 1'b1;
					hb_n = u16[9:0];
				end else if (u16 >= LOW_LO && u16 <= LOW_HI) begin
					has_cp = 1'b1;
					cp     = REPL_CP;
				end else begin
					has_cp = 1'b1;
					cp     = {5'b00000, u16};
				end
			end
		end else if (fmt_q == FMT_UTF32) begin
			if (byte_position_q != 2'd3) begin
				unit_n = {unit_bytes_q[15:0], in_byte};
				pos_n  = byte_position_q + 2'd1;
			end else begin
				pos_n  = 2'd0;
				has_cp = 1'b1;
				if (u32 > CP_MAX || (u32 >= {16'h0000, LOW_LO} - 32'h400
						&& u32 <= {16'h0000, LOW_HI}))
					cp = REPL_CP;
				else
					cp = u32[CP_W-1:0];
			end
		end else begin
			has_cp = 1'b1;
			cp     = {13'd0, in_byte};
		end
	end

	always_comb begin
		q_data.has_cp   = has_cp;
		q_data.cp       = cp;
		q_data.has_repl = in_last && hp_n;
		q_data.last     = in_last;
		q_push          = accept && (has_cp || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q           <= FMT_LATIN1;
			byte_position_q <= '0;
			unit_bytes_q    <= '0;
			high_pending_q  <= 1'b0;
			high_bits_q     <= '0;
		end else begin
			if (source_format_we)
				fmt_q <= source_format;
			if (accept) begin
				if (in_last) begin
					byte_position_q <= '0;
					unit_bytes_q    <= '0;
					high_pending_q  <= 1'b0;
					high_bits_q     <= '0;
				end else begin
					byte_position_q <= pos_n;
					unit_bytes_q    <= unit_n;
					high_pending_q  <= hp_n;
					high_bits_q     <= hb_n;
				end
			end
		end
	end

endmodule

/* hdl/u2u8_queue.sv */
// Two-entry command queue between front and back.
// Depends on u2u8_pkg for the command type.
`timescale 1ns / 1ps
module u2u8_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u2u8_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output u2u8_pkg::cmd_t head
);
	import u2u8_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

/* hdl/u2u8_back.sv */
// Back end: expands commands into UTF-8 bytes, one per cycle while the receiver
// accepts them, into an output register. Depends on u2u8_pkg.
`timescale 1ns / 1ps
module u2u8_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  u2u8_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           byte_valid,
	output logic           run_last,
	output logic           string_end
);
	import u2u8_pkg::*;

	logic       busy_q;
	cmd_t       cmd_q;
	logic       phase_q;    // 0: decoded code point, 1: trailing replacement
	logic [1:0] idx_q;

	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            byte_valid_q;
	logic            run_last_q;
	logic            string_end_q;

	logic [CP_W-1:0] cur_cp;
	logic [1:0]      len_m1;
	logic            marker;
	logic            cp_done;
	logic            final_byte;
	logic            emit;
	logic            load;

	assign cur_cp     = phase_q ? REPL_CP : cmd_q.cp;
	assign len_m1     = utf8_len_m1(cur_cp);
	assign marker     = !cmd_q.has_cp && !cmd_q.has_repl;
	assign cp_done    = (idx_q == len_m1);
	assign final_byte = marker || (cp_done && (phase_q || !cmd_q.has_repl));
	assign emit       = busy_q && (!out_valid_q || out_ready);
	assign load       = q_not_empty && (!busy_q || (emit && final_byte));
	assign q_pop      = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				phase_q <= !q_head.has_cp;
				idx_q   <= '0;
			end else if (emit && final_byte) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				if (cp_done) begin
					phase_q <= 1'b1;
					idx_q   <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			cmd_q <= q_head;
		if (emit) begin
			out_byte_q   <= marker ? 8'h00 : utf8_byte(cur_cp, len_m1, idx_q);
			byte_valid_q <= !marker;
			run_last_q   <= final_byte;
			string_end_q <= final_byte && cmd_q.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

endmodule

/* hdl/utf16_utf32_latin1_to_utf8_core.sv */
// Top level of the UTF-16BE / UTF-32BE / Latin-1 to UTF-8 transcoder.
// Instantiates u2u8_front, u2u8_queue and u2u8_back; depends on u2u8_pkg.
//
// Usage:
// - Input channel (in_valid/in_ready): one source byte per transfer, with
//   in_last marking the final byte of a string. Latin-1 bytes map to U+00xx,
//   UTF-16BE bytes pair into units with surrogate pairs joined, UTF-32BE
//   bytes group into fours. Malformed units produce U+FFFD.
// - Output channel (out_valid/out_ready): one UTF-8 byte per transfer.
//   run_last flags the last byte caused by an input byte, string_end the last
//   byte of a string. A string end with nothing to emit yields one transfer
//   with byte_valid low and out_byte zero.
// - source_format_we/source_format set the source encoding (0 Latin-1,
//   1 UTF-16BE, 2 UTF-32BE, 3 behaves as Latin-1); write it between strings.
// Timing: the front classifies a byte in the cycle it is accepted; its command
// is written into the queue, loaded into the back's command register and then
// expanded into the output byte register. The back emits one UTF-8 byte per
// cycle while the receiver takes them, a rate the output byte register sets.
// An input byte yields none to four bytes: Latin-1 high bytes two, ASCII one.
// A two-entry command queue lets the front keep accepting while the receiver
// stalls; once it fills, in_ready drops until the back drains an entry.
// Reset clears the format to Latin-1 and all unit and surrogate state.
`timescale 1ns / 1ps
module utf16_utf32_latin1_to_utf8_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       source_format_we,
	input  logic [1:0] source_format,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       string_end
);
	import u2u8_pkg::*;

	// Commands flow from the front through the queue to the back.
	cmd_t push_data;
	cmd_t head;
	logic push;
	logic full;
	logic pop;
	logic not_empty;

	u2u8_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.source_format_we (source_format_we),
		.source_format    (source_format),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.in_last          (in_last),
		.q_full           (full),
		.q_push           (push),
		.q_data           (push_data)
	);

	u2u8_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	u2u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_head      (head),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.string_end  (string_end)
	);

endmodule
